// ===== hw/rtl/e2r_pkg.sv =====
// ----------------------------------------------------------------------------
// e2r_pkg
// shared types, fixed-point constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package e2r_pkg;

  localparam int WORK_FRAC       = 30;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ENTRY_FRAC_BITS = 14;
  localparam int CORDIC_STAGES   = 16;

  localparam int WORK_W = 32;  // q30 sine, cosine and residual angle
  localparam int WIDE_W = 34;  // q30 angle before clamping, entry sums

  localparam logic signed [WIDE_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [WIDE_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [WORK_W-1:0] GAIN_Q30    = 32'sd652032874;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
  } out_item_t;

  // folded angle, ready for the cordic
  typedef struct packed {
    logic signed [WORK_W-1:0] z;
    logic                     flip;
  } fold_t;

  typedef struct packed {
    logic  spatial;
    fold_t ax;
    fold_t ay;
    fold_t az;
  } prep_t;

  // q30 arctangent of 2^-i, rounded to nearest
  function automatic logic signed [WORK_W-1:0] atan_q30(input logic [4:0] i);
    logic signed [WORK_W-1:0] r;
    case (i)
      5'd0:    r = 32'sd843314857;
      5'd1:    r = 32'sd497837829;
      5'd2:    r = 32'sd263043837;
      5'd3:    r = 32'sd133525159;
      5'd4:    r = 32'sd67021687;
      5'd5:    r = 32'sd33543516;
      5'd6:    r = 32'sd16775851;
      5'd7:    r = 32'sd8388437;
      5'd8:    r = 32'sd4194283;
      5'd9:    r = 32'sd2097149;
      5'd31:   r = 32'sd0;
      default: r = 32'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/e2r_fifo.sv =====
// ----------------------------------------------------------------------------
// e2r_fifo
// small synchronous queue with registered entries
// ----------------------------------------------------------------------------
module e2r_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW:0]      wr_ptr_q, rd_ptr_q;

  assign full_o  = (wr_ptr_q[AW] != rd_ptr_q[AW]) && (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign rdata_o = mem_q[rd_ptr_q[AW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q[AW-1:0]] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i && !full_o) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i && !empty_o) rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

endmodule

// ===== hw/rtl/e2r_front.sv =====
// ----------------------------------------------------------------------------
// e2r_front
// widens, clamps and quadrant-folds the three angles of a transaction
// ----------------------------------------------------------------------------
module e2r_front
  import e2r_pkg::*;
(
  input  in_item_t item_i,
  input  logic     spatial_i,
  output prep_t    prep_o
);

  function automatic fold_t fold(input logic signed [15:0] a);
    logic signed [WIDE_W-1:0] w;
    fold_t f;
    w = WIDE_W'(a) <<< (WORK_FRAC - ANGLE_FRAC_BITS);
    if (w > PI_Q30) w = PI_Q30;
    if (w < -PI_Q30) w = -PI_Q30;
    f.flip = 1'b0;
    if (w > HALF_PI_Q30) begin
      w = w - PI_Q30;
      f.flip = 1'b1;
    end else if (w < -HALF_PI_Q30) begin
      w = w + PI_Q30;
      f.flip = 1'b1;
    end
    f.z = w[WORK_W-1:0];
    return f;
  endfunction

  always_comb begin
    prep_o.spatial = spatial_i;
    prep_o.ax      = fold(item_i.angle_x);
    prep_o.ay      = fold(item_i.angle_y);
    prep_o.az      = fold(item_i.angle_z);
  end

endmodule

// ===== hw/rtl/e2r_cordic.sv =====
// ----------------------------------------------------------------------------
// e2r_cordic
// unrolled rotation-mode cordic, one registered stage per iteration
// ----------------------------------------------------------------------------
module e2r_cordic
  import e2r_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  fold_t                    ang_i,
  output logic signed [WORK_W-1:0] sin_o,
  output logic signed [WORK_W-1:0] cos_o
);

  logic signed [WORK_W-1:0] x_q [STAGES];
  logic signed [WORK_W-1:0] y_q [STAGES];
  logic signed [WORK_W-1:0] z_q [STAGES];
  logic                     flip_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [WORK_W-1:0] xp, yp, zp, dx, dy, at;
    logic                     fp;

    if (i == 0) begin : g_first
      assign xp = GAIN_Q30;
      assign yp = '0;
      assign zp = ang_i.z;
      assign fp = ang_i.flip;
    end else begin : g_next
      assign xp = x_q[i-1];
      assign yp = y_q[i-1];
      assign zp = z_q[i-1];
      assign fp = flip_q[i-1];
    end

    assign dx = yp >>> i;
    assign dy = xp >>> i;
    assign at = atan_q30(5'(i));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[i] <= fp;
        if (zp >= 0) begin
          x_q[i] <= xp - dx;
          y_q[i] <= yp + dy;
          z_q[i] <= zp - at;
        end else begin
          x_q[i] <= xp + dx;
          y_q[i] <= yp - dy;
          z_q[i] <= zp + at;
        end
      end
    end
  end

  assign sin_o = flip_q[STAGES-1] ? -y_q[STAGES-1] : y_q[STAGES-1];
  assign cos_o = flip_q[STAGES-1] ? -x_q[STAGES-1] : x_q[STAGES-1];

endmodule

// ===== hw/rtl/e2r_back.sv =====
// ----------------------------------------------------------------------------
// e2r_back
// three cordics, two product stages and entry rounding, stalled as one
// ----------------------------------------------------------------------------
module e2r_back
  import e2r_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  prep_t     prep_i,
  output logic      ready_o,
  output logic      valid_o,
  output out_item_t item_o,
  input  logic      ready_i
);

  localparam int SH = WORK_FRAC - ENTRY_FRAC_BITS;
  localparam int LIM = ((1 << ENTRY_FRAC_BITS) > 32767) ? 32767 : (1 << ENTRY_FRAC_BITS);

  typedef logic signed [WORK_W-1:0] w_t;
  typedef logic signed [WIDE_W-1:0] s_t;

  function automatic w_t qmul(input w_t a, input w_t b);
    logic signed [2*WORK_W-1:0] p;
    p = (2*WORK_W)'(a) * (2*WORK_W)'(b) + ((2*WORK_W)'(1) <<< (WORK_FRAC - 1));
    return p[WORK_FRAC +: WORK_W];
  endfunction

  function automatic logic signed [15:0] to_entry(input s_t v);
    s_t r;
    r = (v + (s_t'(1) <<< (SH - 1))) >>> SH;
    if (r > s_t'(LIM)) r = s_t'(LIM);
    if (r < -s_t'(LIM)) r = -s_t'(LIM);
    return r[15:0];
  endfunction

  logic en;
  logic [STAGES-1:0] vld_c_q, mode_c_q;
  logic p1_vld_q, p2_vld_q, p3_vld_q;
  w_t sx, cx, sy, cy, sz, cz;

  // pipeline advances unless a finished transaction is blocked
  assign en      = !(p3_vld_q && !ready_i);
  assign ready_o = en;
  assign valid_o = p3_vld_q;

  e2r_cordic #(.STAGES(STAGES)) u_cx (
    .clk_i(clk_i), .en_i(en), .ang_i(prep_i.ax), .sin_o(sx), .cos_o(cx));
  e2r_cordic #(.STAGES(STAGES)) u_cy (
    .clk_i(clk_i), .en_i(en), .ang_i(prep_i.ay), .sin_o(sy), .cos_o(cy));
  e2r_cordic #(.STAGES(STAGES)) u_cz (
    .clk_i(clk_i), .en_i(en), .ang_i(prep_i.az), .sin_o(sz), .cos_o(cz));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q  <= '0;
      mode_c_q <= '0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
    end else if (en) begin
      vld_c_q  <= {vld_c_q[STAGES-2:0], valid_i};
      mode_c_q <= {mode_c_q[STAGES-2:0], prep_i.spatial};
      p1_vld_q <= vld_c_q[STAGES-1];
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
    end
  end

  // first products
  w_t p1_sxsy_q, p1_cxsy_q, p1_m0_q, p1_m1n_q, p1_m5n_q, p1_m8_q;
  w_t p1_cxsz_q, p1_cxcz_q, p1_sxsz_q, p1_sxcz_q;
  w_t p1_sx_q, p1_cx_q, p1_sy_q, p1_sz_q, p1_cz_q;
  logic p1_mode_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_sxsy_q <= qmul(sx, sy);
      p1_cxsy_q <= qmul(cx, sy);
      p1_m0_q   <= qmul(cy, cz);
      p1_m1n_q  <= qmul(cy, sz);
      p1_m5n_q  <= qmul(sx, cy);
      p1_m8_q   <= qmul(cx, cy);
      p1_cxsz_q <= qmul(cx, sz);
      p1_cxcz_q <= qmul(cx, cz);
      p1_sxsz_q <= qmul(sx, sz);
      p1_sxcz_q <= qmul(sx, cz);
      p1_sx_q   <= sx;
      p1_cx_q   <= cx;
      p1_sy_q   <= sy;
      p1_sz_q   <= sz;
      p1_cz_q   <= cz;
      p1_mode_q <= mode_c_q[STAGES-1];
    end
  end

  // triple products
  w_t p2_t3_q, p2_t4_q, p2_t6_q, p2_t7_q;
  w_t p2_m0_q, p2_m1n_q, p2_m5n_q, p2_m8_q;
  w_t p2_cxsz_q, p2_cxcz_q, p2_sxsz_q, p2_sxcz_q;
  w_t p2_sx_q, p2_cx_q, p2_sy_q;
  logic p2_mode_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_t3_q   <= qmul(p1_sxsy_q, p1_cz_q);
      p2_t4_q   <= qmul(p1_sxsy_q, p1_sz_q);
      p2_t6_q   <= qmul(p1_cxsy_q, p1_cz_q);
      p2_t7_q   <= qmul(p1_cxsy_q, p1_sz_q);
      p2_m0_q   <= p1_m0_q;
      p2_m1n_q  <= p1_m1n_q;
      p2_m5n_q  <= p1_m5n_q;
      p2_m8_q   <= p1_m8_q;
      p2_cxsz_q <= p1_cxsz_q;
      p2_cxcz_q <= p1_cxcz_q;
      p2_sxsz_q <= p1_sxsz_q;
      p2_sxcz_q <= p1_sxcz_q;
      p2_sx_q   <= p1_sx_q;
      p2_cx_q   <= p1_cx_q;
      p2_sy_q   <= p1_sy_q;
      p2_mode_q <= p1_mode_q;
    end
  end

  // sums, rounding and planar selection
  out_item_t p3_d, p3_q;
  s_t zero_s;

  always_comb begin
    zero_s = '0;
    if (p2_mode_q) begin
      p3_d.r00 = to_entry(s_t'(p2_m0_q));
      p3_d.r01 = to_entry(-s_t'(p2_m1n_q));
      p3_d.r02 = to_entry(s_t'(p2_sy_q));
      p3_d.r10 = to_entry(s_t'(p2_t3_q) + s_t'(p2_cxsz_q));
      p3_d.r11 = to_entry(-s_t'(p2_t4_q) + s_t'(p2_cxcz_q));
      p3_d.r12 = to_entry(-s_t'(p2_m5n_q));
      p3_d.r20 = to_entry(-s_t'(p2_t6_q) + s_t'(p2_sxsz_q));
      p3_d.r21 = to_entry(s_t'(p2_t7_q) + s_t'(p2_sxcz_q));
      p3_d.r22 = to_entry(s_t'(p2_m8_q));
    end else begin
      p3_d.r00 = to_entry(s_t'(p2_cx_q));
      p3_d.r01 = to_entry(-s_t'(p2_sx_q));
      p3_d.r02 = to_entry(zero_s);
      p3_d.r10 = to_entry(s_t'(p2_sx_q));
      p3_d.r11 = to_entry(s_t'(p2_cx_q));
      p3_d.r12 = to_entry(zero_s);
      p3_d.r20 = to_entry(zero_s);
      p3_d.r21 = to_entry(zero_s);
      p3_d.r22 = to_entry(zero_s);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) p3_q <= p3_d;
  end

  assign item_o = p3_q;

endmodule

// ===== hw/rtl/euler_to_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// tait-bryan angles (x, y, z) to a 3x3 rotation matrix rx * ry * rz
// ----------------------------------------------------------------------------
// Takes one angle set per transaction (q2.13 radians, clamped to +-pi) and
// returns one matrix per transaction (q1.14 entries, saturated at +-1). In
// planar mode only angle_x is used and the matrix is the 2x2 rotation in the
// upper left corner with all other entries zero. The block sustains one
// transaction per clock unless the result queue is full: the cordic and
// the product stages are fully unrolled, so a transaction passes through
// the front queue, one registered stage per cordic iteration, two product
// stages, one rounding stage and the result queue. The mode register is
// sampled as a transaction is pushed; write it only while the block is idle.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix
  import e2r_pkg::*;
#(
  parameter int CORDIC_STAGES = e2r_pkg::CORDIC_STAGES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  // input queue side
  input  logic      push,
  input  in_item_t  in_data_i,
  output logic      full,
  // result queue side
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data_o,
  // mode register write channel
  input  logic      cfg_valid_i,
  input  logic      cfg_data_i,
  output logic      cfg_ready_o
);

  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  // mode register, 1 = spatial
  logic spatial_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spatial_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      spatial_q <= cfg_data_i;
    end
  end

  // front: fold angles into the cordic range
  prep_t prep, mid_rdata;
  logic  mid_empty, back_ready;

  e2r_front u_front (
    .item_i   (in_data_i),
    .spatial_i(spatial_q),
    .prep_o   (prep)
  );

  // queue between front and back so each side stalls on its own
  e2r_fifo #(.WIDTH($bits(prep_t)), .DEPTH(MID_DEPTH)) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(prep),
    .full_o (full),
    .pop_i  (back_ready),
    .rdata_o(mid_rdata),
    .empty_o(mid_empty)
  );

  // back: sine/cosine and matrix products
  out_item_t back_item;
  logic      back_valid, out_full;

  e2r_back #(.STAGES(CORDIC_STAGES)) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(!mid_empty),
    .prep_i (mid_rdata),
    .ready_o(back_ready),
    .valid_o(back_valid),
    .item_o (back_item),
    .ready_i(!out_full)
  );

  // result queue, decouples the pipeline from the consumer
  e2r_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(OUT_DEPTH)) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (back_valid),
    .wdata_i(back_item),
    .full_o (out_full),
    .pop_i  (pop),
    .rdata_o(out_data_o),
    .empty_o(empty)
  );

endmodule
